// ===== sv/mtep_pkg.sv =====
// Package for the MIDI track event parser: payload structs, parse phases,
// event kinds and status byte constants. No dependencies.
`timescale 1ns / 1ps

package mtep_pkg;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        track_start;
		logic [15:0] track_number;
	} in_t;

	typedef enum logic [1:0] {
		KIND_NOTE_ON  = 2'd0,
		KIND_NOTE_OFF = 2'd1,
		KIND_TEMPO    = 2'd2
	} kind_t;

	typedef struct packed {
		logic [31:0] event_ticks;
		logic [1:0]  event_kind;
		logic [7:0]  note_number;
		logic [7:0]  velocity;
		logic [23:0] tempo_usec;
		logic [15:0] track_id;
	} out_t;

	typedef enum logic [3:0] {
		PH_DELTA     = 4'd0,
		PH_STATUS    = 4'd1,
		PH_NOTE_KEY  = 4'd2,
		PH_NOTE_VEL  = 4'd3,
		PH_META_TYPE = 4'd4,
		PH_META_LEN  = 4'd5,
		PH_TEMPO     = 4'd6,
		PH_SYSEX_LEN = 4'd7,
		PH_SKIP      = 4'd8
	} phase_t;

	localparam logic [7:0] DATA_MASK   = 8'h7F;
	localparam logic [7:0] STATUS_BIT  = 8'h80;
	localparam logic [7:0] HI_MASK     = 8'hF0;
	localparam logic [7:0] HI_NOTE_OFF = 8'h80;
	localparam logic [7:0] HI_NOTE_ON  = 8'h90;
	localparam logic [7:0] HI_PROGRAM  = 8'hC0;
	localparam logic [7:0] HI_PRESSURE = 8'hD0;
	localparam logic [7:0] ST_SYSEX    = 8'hF0;
	localparam logic [7:0] ST_ESCAPE   = 8'hF7;
	localparam logic [7:0] ST_META     = 8'hFF;
	localparam logic [7:0] META_TEMPO  = 8'h51;
	localparam logic [31:0] TEMPO_LEN  = 32'd3;
	localparam logic [1:0] TEMPO_LAST  = 2'd3;

endpackage

// ===== sv/mtep_core.sv =====
// Parse state registers and per-byte decode for the MIDI track event parser.
// Depends on mtep_pkg. State advances on each accepted byte; result is combinational.
`timescale 1ns / 1ps

module mtep_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  mtep_pkg::in_t    req,
	output logic             res_valid,
	output mtep_pkg::out_t   res
);

	mtep_pkg::phase_t phase_q, phase_d;
	logic [31:0] len_q, len_d;
	logic [31:0] ticks_q, ticks_d;
	logic [7:0]  running_q, running_d;
	logic [7:0]  current_q, current_d;
	logic [7:0]  first_q, first_d;
	logic [7:0]  meta_q, meta_d;
	logic [31:0] skip_q, skip_d;
	logic [23:0] tempo_q, tempo_d;
	logic [1:0]  idx_q, idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= mtep_pkg::PH_DELTA;
			len_q     <= '0;
			ticks_q   <= '0;
			running_q <= '0;
			current_q <= '0;
			first_q   <= '0;
			meta_q    <= '0;
			skip_q    <= '0;
			tempo_q   <= '0;
			idx_q     <= '0;
		end else if (take) begin
			phase_q   <= phase_d;
			len_q     <= len_d;
			ticks_q   <= ticks_d;
			running_q <= running_d;
			current_q <= current_d;
			first_q   <= first_d;
			meta_q    <= meta_d;
			skip_q    <= skip_d;
			tempo_q   <= tempo_d;
			idx_q     <= idx_d;
		end
	end

	logic [7:0]  b;
	logic        is_status;
	logic        vlq_end;
	logic [31:0] vlq;
	logic [7:0]  st;
	logic [7:0]  hi;
	logic [31:0] params;
	logic [31:0] skip_n;
	logic        do_skip;
	logic [23:0] tempo_next;
	logic [1:0]  idx_next;
	mtep_pkg::phase_t phase_c;
	logic [31:0] len_c, ticks_c, skip_c;
	logic [7:0]  running_c, current_c, first_c, meta_c;
	logic [23:0] tempo_c;
	logic [1:0]  idx_c;

	always_comb begin
		b = req.data_byte;
		// track start clears state ahead of this byte
		if (req.track_start) begin
			phase_c = mtep_pkg::PH_DELTA; len_c = '0; ticks_c = '0; running_c = '0;
			current_c = '0; first_c = '0; meta_c = '0; skip_c = '0; tempo_c = '0;
			idx_c = '0;
		end else begin
			phase_c = phase_q; len_c = len_q; ticks_c = ticks_q; running_c = running_q;
			current_c = current_q; first_c = first_q; meta_c = meta_q; skip_c = skip_q;
			tempo_c = tempo_q; idx_c = idx_q;
		end

		is_status = (b & mtep_pkg::STATUS_BIT) != 8'd0;
		vlq_end   = !is_status;
		vlq       = {len_c[24:0], b[6:0]};
		st        = is_status ? b : running_c;
		hi        = st & mtep_pkg::HI_MASK;
		params    = (hi == mtep_pkg::HI_PROGRAM || hi == mtep_pkg::HI_PRESSURE) ? 32'd1 : 32'd2;
		tempo_next = {tempo_c[15:0], b};
		idx_next   = idx_c + 2'd1;

		phase_d = phase_c; len_d = len_c; ticks_d = ticks_c; running_d = running_c;
		current_d = current_c; first_d = first_c; meta_d = meta_c; skip_d = skip_c;
		tempo_d = tempo_c; idx_d = idx_c;

		skip_n  = '0;
		do_skip = 1'b0;

		res_valid       = 1'b0;
		res.event_ticks = ticks_c;
		res.event_kind  = mtep_pkg::KIND_NOTE_OFF;
		res.note_number = first_c;
		res.velocity    = b;
		res.tempo_usec  = '0;
		res.track_id    = req.track_number;

		unique case (phase_c)
			mtep_pkg::PH_STATUS: begin
				current_d = st;
				if (is_status) running_d = b;
				if (hi == mtep_pkg::HI_NOTE_ON || hi == mtep_pkg::HI_NOTE_OFF) begin
					if (is_status) begin
						phase_d = mtep_pkg::PH_NOTE_KEY;
					end else begin
						first_d = b;
						phase_d = mtep_pkg::PH_NOTE_VEL;
					end
				end else if (st == mtep_pkg::ST_META) begin
					if (is_status) begin
						phase_d = mtep_pkg::PH_META_TYPE;
					end else begin
						meta_d  = b;
						len_d   = '0;
						phase_d = mtep_pkg::PH_META_LEN;
					end
				end else if (st == mtep_pkg::ST_SYSEX || st == mtep_pkg::ST_ESCAPE) begin
					len_d = '0;
					if (is_status) begin
						phase_d = mtep_pkg::PH_SYSEX_LEN;
					end else begin
						// data byte is the first length byte; accumulator starts empty
						do_skip = 1'b1;
						skip_n  = {25'd0, b[6:0]};
					end
				end else begin
					do_skip = 1'b1;
					skip_n  = is_status ? params : params - 32'd1;
				end
			end
			mtep_pkg::PH_NOTE_KEY: begin
				first_d = b;
				phase_d = mtep_pkg::PH_NOTE_VEL;
			end
			mtep_pkg::PH_NOTE_VEL: begin
				res_valid = 1'b1;
				if ((current_c & mtep_pkg::HI_MASK) == mtep_pkg::HI_NOTE_ON && b != 8'd0)
					res.event_kind = mtep_pkg::KIND_NOTE_ON;
				phase_d = mtep_pkg::PH_DELTA;
			end
			mtep_pkg::PH_META_TYPE: begin
				meta_d  = b;
				len_d   = '0;
				phase_d = mtep_pkg::PH_META_LEN;
			end
			mtep_pkg::PH_META_LEN: begin
				if (vlq_end) begin
					len_d = '0;
					if (meta_c == mtep_pkg::META_TEMPO && vlq == mtep_pkg::TEMPO_LEN) begin
						tempo_d = '0;
						idx_d   = '0;
						phase_d = mtep_pkg::PH_TEMPO;
					end else begin
						do_skip = 1'b1;
						skip_n  = vlq;
					end
				end else begin
					len_d = vlq;
				end
			end
			mtep_pkg::PH_TEMPO: begin
				tempo_d = tempo_next;
				idx_d   = idx_next;
				if (idx_next == mtep_pkg::TEMPO_LAST) begin
					res_valid       = 1'b1;
					res.event_kind  = mtep_pkg::KIND_TEMPO;
					res.note_number = '0;
					res.velocity    = '0;
					res.tempo_usec  = tempo_next;
					idx_d   = '0;
					phase_d = mtep_pkg::PH_DELTA;
				end
			end
			mtep_pkg::PH_SYSEX_LEN: begin
				if (vlq_end) begin
					len_d   = '0;
					do_skip = 1'b1;
					skip_n  = vlq;
				end else begin
					len_d = vlq;
				end
			end
			mtep_pkg::PH_SKIP: begin
				skip_d = skip_c - 32'd1;
				if (skip_d == 32'd0) phase_d = mtep_pkg::PH_DELTA;
			end
			default: begin
				// delta time; unused phase codes land here too
				if (vlq_end) begin
					ticks_d = ticks_c + vlq;
					len_d   = '0;
					phase_d = mtep_pkg::PH_STATUS;
				end else begin
					len_d   = vlq;
					phase_d = mtep_pkg::PH_DELTA;
				end
			end
		endcase

		if (do_skip) begin
			if (skip_n == 32'd0) begin
				phase_d = mtep_pkg::PH_DELTA;
			end else begin
				skip_d  = skip_n;
				phase_d = mtep_pkg::PH_SKIP;
			end
		end
	end

endmodule

// ===== sv/midi_track_event_parser.sv =====
// MIDI track event parser: one track body byte per cycle unless stalled, note and tempo events out.
// Output: a byte that completes an event shows its result in the cycle after acceptance.
// Throughput: one byte per cycle; the output register holds a stalled result while
// bytes that make no result keep flowing, a result-making byte waits for it.
// Reset: arst_n clears parse state and the output valid flag; track_start clears parse state.
// Depends on mtep_pkg and mtep_core.
`timescale 1ns / 1ps

module midi_track_event_parser (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             byte_valid,
	output logic             byte_stall,
	input  mtep_pkg::in_t    byte_data,
	output logic             event_valid,
	input  logic             event_stall,
	output mtep_pkg::out_t   event_data
);

	logic           take;
	logic           res_valid;
	mtep_pkg::out_t res;
	logic           ev_valid_q;
	mtep_pkg::out_t ev_data_q;
	logic           out_busy;

	mtep_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.req       (byte_data),
		.res_valid (res_valid),
		.res       (res)
	);

	assign out_busy   = ev_valid_q && event_stall;
	// only a request that makes a result has to wait on a held result
	assign byte_stall = out_busy && res_valid;
	assign take       = byte_valid && !byte_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_valid_q <= 1'b0;
		end else if (take && res_valid) begin
			ev_valid_q <= 1'b1;
		end else if (!event_stall) begin
			ev_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && res_valid) ev_data_q <= res;
	end

	assign event_valid = ev_valid_q;
	assign event_data  = ev_data_q;

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (event_valid && event_stall))
		else $error("input stalled without a held result");

	a_result_registered: assert property (@(posedge clk) disable iff (!arst_n)
		(take && res_valid) |=> (event_valid && event_data == $past(res)))
		else $error("result not presented after producing request");

	a_held_result_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(event_valid && event_stall) |=> event_valid)
		else $error("stalled result dropped");

endmodule
